// ===== src/comb_sort_engine_top_defines.svh =====
// assertion macros shared by the comb sort engine checker
// no dependencies; included by the files that hold assertions
`ifndef COMB_SORT_ENGINE_TOP_DEFINES_SVH
`define COMB_SORT_ENGINE_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define CSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CSE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cse_pkg.sv =====
// constants shared by the comb sort engine and its checker
// no dependencies
package cse_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);

    // gap shrink: floor(gap * 10 / 13), the divide done as a reciprocal multiply
    localparam int SHRINK_NUM   = 10;
    localparam int RECIP_13     = 5042;
    localparam int RECIP_SHIFT  = 16;
    localparam int RECIP_W      = 13;
    localparam int GAP_TEN_W    = CNT_W + 4;
    localparam int PROD_W       = GAP_TEN_W + RECIP_W;

endpackage

// ===== src/comb_sort_engine_top.sv =====
// comb sort engine: key store, shared compare-swap unit and its sequencer
// depends on cse_pkg
//
// Keys arrive one request at a time on the s_ channel and are written to a
// 64-entry store as they are taken; a key that arrives with the store full is
// dropped. The request with s_tlast high closes the set: the input goes not
// ready and a single compare unit, fed by a two-read, one-write memory, comb
// sorts the set in place. Each pass has a setup step and a pass-end step and,
// for every pair gap apart, a read step and a compare step, plus a swap step
// when the pair is swapped; the number of passes follows the 10/13 gap
// schedule plus any extra gap-one passes. The memory write port (one word a
// cycle) is why a swap needs its own step. Sorted keys then leave on the m_
// channel in ascending signed order, each read from the store and then loaded
// into the output register, with m_tlast on the last.
// The output register lets a new set start loading while the final key of
// the previous set still waits to be taken.
module comb_sort_engine_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic signed [cse_pkg::KEY_W-1:0] s_tdata,   // [31:0] key
    input  logic                             s_tlast,   // last
    // result requests
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic signed [cse_pkg::KEY_W-1:0] m_tdata,   // [31:0] sorted_key
    output logic                             m_tlast    // final_res
);

    localparam int KW = cse_pkg::KEY_W;
    localparam int IW = cse_pkg::IDX_W;
    localparam int CW = cse_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_SCAN,
        ST_CMP,
        ST_SWAP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      fill_reg, fill_next;      // keys loaded so far
    logic [CW-1:0]      num_reg, num_next;        // size of the set being sorted
    logic [CW-1:0]      gap_reg, gap_next;
    logic               done_reg, done_next;      // gap-one pass with no swap so far
    logic [IW-1:0]      idx_reg, idx_next;        // lower index of the pair
    logic [CW-1:0]      out_reg, out_next;        // next key to emit
    logic               m_tvalid_reg, m_tvalid_next;
    logic [KW-1:0]      m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;

    // key store, two registered read ports and one write port
    logic [KW-1:0]      key_mem [cse_pkg::MAX_KEYS];
    logic [KW-1:0]      rd_a_reg, rd_b_reg;
    logic [IW-1:0]      rd_addr_a, rd_addr_b;
    logic               rd_en;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [KW-1:0]      wr_data;

    // gap shrink arithmetic
    logic [cse_pkg::GAP_TEN_W-1:0] gap_ten;
    logic [cse_pkg::PROD_W-1:0]    gap_prod;
    logic [CW-1:0]                 gap_quot;
    logic [CW-1:0]                 gap_new;

    // pair upper index, one bit wider so idx + gap cannot wrap
    logic [CW:0]        pair_hi;
    logic               pair_ok;
    logic               key_gt;
    logic               s_acc;
    logic               out_free;
    logic               more_passes;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // output register can take a new key when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    assign gap_ten  = cse_pkg::GAP_TEN_W'(gap_reg)
                    * cse_pkg::GAP_TEN_W'(cse_pkg::SHRINK_NUM);
    assign gap_prod = cse_pkg::PROD_W'(gap_ten) * cse_pkg::PROD_W'(cse_pkg::RECIP_13);
    assign gap_quot = gap_prod[cse_pkg::RECIP_SHIFT +: CW];
    assign gap_new  = (gap_quot == '0) ? CW'(1) : gap_quot;

    assign pair_hi  = (CW+1)'(idx_reg) + (CW+1)'(gap_reg);
    assign pair_ok  = pair_hi < (CW+1)'(num_reg);

    // signed compare of the two keys read for the current pair
    assign key_gt   = $signed(rd_a_reg) > $signed(rd_b_reg);

    // another pass unless gap is one and that pass made no swap
    assign more_passes = (gap_reg > CW'(1)) || !done_reg;

    // read addresses: the pair during the sort, the emit pointer afterwards
    always_comb begin
        if (state_reg == ST_EMIT_RD) begin
            rd_addr_a = out_reg[IW-1:0];
        end else begin
            rd_addr_a = idx_reg;
        end
        rd_addr_b = pair_hi[IW-1:0];
        rd_en     = (state_reg == ST_SCAN) || (state_reg == ST_EMIT_RD);
    end

    // write port: loading, then the two halves of a swap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[IW-1:0];
        wr_data = s_tdata;
        unique case (state_reg)
            ST_LOAD: begin
                wr_en = s_acc && (fill_reg < CW'(cse_pkg::MAX_KEYS));
            end
            ST_CMP: begin
                wr_en   = key_gt;
                wr_addr = idx_reg;
                wr_data = rd_b_reg;
            end
            ST_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = pair_hi[IW-1:0];
                wr_data = rd_a_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= key_mem[rd_addr_a];
            rd_b_reg <= key_mem[rd_addr_b];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        num_next      = num_reg;
        gap_next      = gap_reg;
        done_next     = done_reg;
        idx_next      = idx_reg;
        out_next      = out_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        // a taken result frees the output register
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (fill_reg < CW'(cse_pkg::MAX_KEYS)) begin
                        fill_next = fill_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        // close the set and start sorting
                        num_next   = (fill_reg < CW'(cse_pkg::MAX_KEYS))
                                   ? fill_reg + CW'(1) : fill_reg;
                        gap_next   = num_next;
                        done_next  = 1'b0;
                        fill_next  = '0;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                gap_next   = gap_new;
                done_next  = (gap_new == CW'(1)) ? 1'b1 : done_reg;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pair_ok) begin
                    state_next = ST_CMP;
                end else if (more_passes) begin
                    state_next = ST_PASS;
                end else begin
                    out_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_CMP: begin
                if (key_gt) begin
                    if (gap_reg == CW'(1)) begin
                        done_next = 1'b0;
                    end
                    state_next = ST_SWAP;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SWAP: begin
                idx_next   = idx_reg + IW'(1);
                state_next = ST_SCAN;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rd_a_reg;
                    m_tlast_next  = (out_reg + CW'(1) == num_reg);
                    out_next      = out_reg + CW'(1);
                    state_next    = (out_reg + CW'(1) == num_reg) ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            num_reg      <= '0;
            gap_reg      <= '0;
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            out_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            num_reg      <= num_next;
            gap_reg      <= gap_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
            out_reg      <= out_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

// ===== src/cse_checker.sv =====
// port-level checks for the comb sort engine, bound to the top level
// depends on cse_pkg and comb_sort_engine_top_defines.svh
`include "comb_sort_engine_top_defines.svh"

module cse_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cse_pkg::KEY_W-1:0]   m_tdata,
    input logic                        m_tlast
);

    // a stalled result holds its payload
    `CSE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // closing a set makes the input busy while the sort runs
    `CSE_ASSERT(a_busy_after_last, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "input ready straight after the last key")

    // no key is taken while a non-final result of a set is out
    `CSE_ASSERT(a_no_load_mid_run, aclk, aresetn, m_tvalid && !m_tlast |-> !s_tready, "input ready in the middle of a sorted run")

    // reset empties the output
    `CSE_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind comb_sort_engine_top cse_checker u_cse_checker (.*);

// ===== tb/tb_top.sv =====
// self-checking bench for comb_sort_engine_top: random and directed key sets, sorted order checked
// depends on cse_pkg and comb_sort_engine_top
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 64;

    typedef logic signed [cse_pkg::KEY_W-1:0] key_t;

    // keeps its own copy of the key store, sorts each closed set and queues the order
    class sort_scoreboard;
        key_t        held_keys[cse_pkg::MAX_KEYS];
        int unsigned held_count;
        key_t        sorted_q[$];
        bit          tail_q[$];
        int          errors;
        int          checked;
        int          sets_closed;
        int          keys_dropped;

        function new();
            held_count   = 0;
            errors       = 0;
            checked      = 0;
            sets_closed  = 0;
            keys_dropped = 0;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // shrinking-gap sort of the held keys, ascending signed
        function void comb_sort();
            int unsigned gap;
            bit          settled;
            key_t        lo;
            key_t        hi;
            gap     = held_count;
            settled = 1'b0;
            while (gap > 1 || !settled) begin
                gap = (gap * 10) / 13;
                if (gap < 1)
                    gap = 1;
                if (gap == 1)
                    settled = 1'b1;
                for (int unsigned i = 0; i + gap < held_count; i++) begin
                    lo = held_keys[i];
                    hi = held_keys[i + gap];
                    if (lo > hi) begin
                        held_keys[i]       = hi;
                        held_keys[i + gap] = lo;
                        if (gap == 1)
                            settled = 1'b0;
                    end
                end
            end
        endfunction

        // called for every accepted input request
        function void note_key(key_t key, logic is_last);
            if (held_count < cse_pkg::MAX_KEYS) begin
                held_keys[held_count] = key;
                held_count++;
            end else begin
                keys_dropped++;
            end
            if (is_last) begin
                comb_sort();
                for (int unsigned k = 0; k < held_count; k++) begin
                    sorted_q.push_back(held_keys[k]);
                    tail_q.push_back(k + 1 == held_count);
                end
                held_count = 0;
                sets_closed++;
            end
        endfunction

        // called for every accepted result request
        task check_result(key_t got_key, logic got_tail);
            key_t want_key;
            bit   want_tail;
            if (sorted_q.size() == 0) begin
                report($sformatf("result with nothing expected: key %0d tlast %b",
                                 got_key, got_tail));
                return;
            end
            want_key  = sorted_q.pop_front();
            want_tail = tail_q.pop_front();
            checked++;
            if (got_key !== want_key)
                report($sformatf("result %0d key %0d, expected %0d",
                                 checked, got_key, want_key));
            if (got_tail !== want_tail)
                report($sformatf("result %0d tlast %b, expected %b",
                                 checked, got_tail, want_tail));
        endtask

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    key_t s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    key_t m_tdata;
    logic m_tlast;

    sort_scoreboard sb;
    int             send_idle;
    int             recv_stall;
    int             cycle_count;
    int             keys_sent;

    comb_sort_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("comb_sort_engine_top regression: fail");
            $finish;
        end
    end

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // one input request; valid stays high into the next request when no gap is drawn
    task automatic send_key(key_t key, logic is_last);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        sb.note_key(key, is_last);
        keys_sent++;
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(3))
            0: return key_t'($urandom_range(15)) - key_t'(8);
            1: begin
                case ($urandom_range(5))
                    0: return key_t'(32'h8000_0000);
                    1: return key_t'(32'h7FFF_FFFF);
                    2: return key_t'(32'h0000_0000);
                    3: return key_t'(32'hFFFF_FFFF);
                    4: return key_t'(32'h0001_0000);
                    default: return key_t'(32'hFFFF_0000);
                endcase
            end
            default: return key_t'($urandom());
        endcase
    endfunction

    task automatic send_random_set(int n);
        for (int i = 1; i <= n; i++)
            send_key(pick_key(), i == n);
    endtask

    // hold the sender off until every sorted key has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(int idle, int stall, int budget, bit with_overflow);
        int sent;
        int n;
        send_idle  = idle;
        recv_stall = stall;
        sent       = 0;
        // overflowing set: the last three keys, the flagged one among them, are dropped
        if (with_overflow) begin
            send_random_set(cse_pkg::MAX_KEYS + 3);
            sent += cse_pkg::MAX_KEYS + 3;
        end
        while (sent < budget) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 8);
            send_random_set(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        sb         = new();
        send_idle  = 0;
        recv_stall = 0;
        keys_sent  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single keys at both extremes
        send_key(key_t'(32'h7FFF_FFFF), 1'b1);
        send_key(key_t'(32'h8000_0000), 1'b1);
        // sign boundaries and whole values mixed
        send_key(key_t'(32'h0000_0000), 1'b0);
        send_key(key_t'(32'hFFFF_FFFF), 1'b0);
        send_key(key_t'(32'h8000_0000), 1'b0);
        send_key(key_t'(32'h7FFF_FFFF), 1'b0);
        send_key(key_t'(32'h0000_0001), 1'b0);
        send_key(key_t'(32'h0001_0000), 1'b0);
        send_key(key_t'(32'hFFFF_0000), 1'b1);
        // repeated keys
        send_key(key_t'(5), 1'b0);
        send_key(key_t'(5), 1'b0);
        send_key(-key_t'(3), 1'b0);
        send_key(key_t'(5), 1'b0);
        send_key(-key_t'(3), 1'b1);
        // strictly descending set
        for (int i = 0; i < 8; i++)
            send_key(key_t'(1000 - 300 * i), i == 7);
        drain();

        run_phase(0, 0, 20, 1'b0);
        run_phase(83, 0, 20, 1'b0);
        run_phase(0, 83, 20, 1'b0);
        run_phase(27, 27, 75, 1'b1);

        // let any stray result show up before closing
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d sorted keys never came out", sb.pending()));

        $display("sent %0d keys in %0d sets (%0d dropped on a full store)",
                 keys_sent, sb.sets_closed, sb.keys_dropped);
        $display("checked %0d sorted keys, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("comb_sort_engine_top regression: pass");
        else
            $display("comb_sort_engine_top regression: fail");
        $finish;
    end

endmodule
